[design/piecewise_cubic_key_evaluator_core_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the piecewise cubic key evaluator
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while the active-low reset is held.
// ----------------------------------------------------------------------------
`ifndef PIECEWISE_CUBIC_KEY_EVALUATOR_CORE_ASSERT_SVH
`define PIECEWISE_CUBIC_KEY_EVALUATOR_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PCKE_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pcke assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define PCKE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pcke assertion failed");

`endif

[design/pcke_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pcke_pkg
// Sizes, key record layout and helper types shared by the key evaluator.
// ----------------------------------------------------------------------------
package pcke_pkg;

    localparam int MAX_KEYS  = 256;
    localparam int KEY_AW    = $clog2(MAX_KEYS);
    localparam int CNT_W     = KEY_AW + 1;
    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int COEF_W    = 4 * DATA_W;
    localparam int IDX_W     = 8;
    localparam int CFG_W     = 9;

    // coefficient slots inside one 128-bit key record, lowest first
    localparam int COEF_CUBIC  = 0;
    localparam int COEF_SQUARE = 1;
    localparam int COEF_LINEAR = 2;
    localparam int COEF_CONST  = 3;

    // input beat layout (tdata), lowest bit first
    localparam int IN_W       = IDX_W + 6 * DATA_W;
    localparam int OFS_KIDX   = 0;
    localparam int OFS_KTIME  = OFS_KIDX + IDX_W;
    localparam int OFS_COEF   = OFS_KTIME + DATA_W;
    localparam int OFS_QTIME  = OFS_COEF + COEF_W;

    // kind codes carried in tuser
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // product of a signed accumulator and an unsigned offset
    localparam int PROD_W = 2 * DATA_W + 1;
    localparam int SAT_W  = PROD_W + 1;

    typedef struct packed {
        logic                en;
        logic [KEY_AW-1:0]   addr;
        logic [DATA_W-1:0]   key_time;
        logic [COEF_W-1:0]   coef;
    } t_key_wr;

    typedef struct packed {
        logic                time_en;
        logic                coef_en;
        logic [KEY_AW-1:0]   addr;
    } t_key_rd;

    // clamp a wide signed value to the signed 32-bit range
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
        logic fits;
        fits = (&v[SAT_W-1:DATA_W-1]) || !(|v[SAT_W-1:DATA_W-1]);
        if (fits) begin
            sat32 = v[DATA_W-1:0];
        end else if (v[SAT_W-1]) begin
            sat32 = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            sat32 = {1'b0, {(DATA_W-1){1'b1}}};
        end
    endfunction

endpackage
`default_nettype wire

[design/pcke_key_store.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pcke_key_store
// Key table: start-time memory and coefficient memory, one write port,
// one registered read port each.
// ----------------------------------------------------------------------------
module pcke_key_store (
    input  wire logic                          i_clk,
    input  wire pcke_pkg::t_key_wr             i_wr,
    input  wire pcke_pkg::t_key_rd             i_rd,
    output logic [pcke_pkg::DATA_W-1:0]        o_time,
    output logic [pcke_pkg::COEF_W-1:0]        o_coef
);
    import pcke_pkg::*;

    logic [DATA_W-1:0] r_time_mem [MAX_KEYS];
    logic [COEF_W-1:0] r_coef_mem [MAX_KEYS];
    logic [DATA_W-1:0] r_time_q;
    logic [COEF_W-1:0] r_coef_q;

    // time table
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_time_mem[i_wr.addr] <= i_wr.key_time;
        end
        if (i_rd.time_en) begin
            r_time_q <= r_time_mem[i_rd.addr];
        end
    end

    // coefficient table
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_coef_mem[i_wr.addr] <= i_wr.coef;
        end
        if (i_rd.coef_en) begin
            r_coef_q <= r_coef_mem[i_rd.addr];
        end
    end

    assign o_time = r_time_q;
    assign o_coef = r_coef_q;

endmodule
`default_nettype wire

[design/piecewise_cubic_key_evaluator_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// piecewise_cubic_key_evaluator_core
// Piecewise cubic curve evaluator over a table of time-sorted keys.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: tuser = kind (0 key write, 1 query). tdata carries key_index,
//   key_time, the four coefficients (cubic, square, linear, const) and
//   query_time. A key write is stored in the accept cycle and gives no beat.
//   i_cfg_we/i_cfg_wdata set key_count; write it only while the block idles.
//   A query binary-searches the start-time memory, one probe per cycle with
//   the next address issued from the compare, then fetches the selected key
//   and runs three Horner stages (multiply cycle, shift/saturate/add cycle).
//   The search takes floor(log2(count)) probes or one more (at most 9 for a
//   full table of 256 keys); an empty table skips the search, fetch and
//   Horner stages and goes straight to the output register.
//   One query is in flight at a time; while idle, a key write can be accepted
//   every cycle. Output: tdata = curve_value, tuser = empty_table. The result
//   sits in an output register; a stalled receiver holds it, and the block keeps
//   taking beats until a new result needs that register.
//   Reset (synchronous, active low) clears key_count, control and the output
//   valid. Table contents are undefined until written; no clearing pass.
// ----------------------------------------------------------------------------
module piecewise_cubic_key_evaluator_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // config: key_count
    input  wire logic                          i_cfg_we,
    input  wire logic [pcke_pkg::CFG_W-1:0]    i_cfg_wdata,
    // input stream
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // tdata: key_index[7:0], key_time[39:8], coef_cubic[71:40],
    //        coef_square[103:72], coef_linear[135:104], coef_const[167:136],
    //        query_time[199:168]
    input  wire logic [pcke_pkg::IN_W-1:0]     i_s_axis_tdata,
    // tuser: kind[0]
    input  wire logic [0:0]                    i_s_axis_tuser,
    // output stream
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    // tdata: curve_value[31:0]
    output logic [pcke_pkg::DATA_W-1:0]        o_m_axis_tdata,
    // tuser: empty_table[0]
    output logic [0:0]                         o_m_axis_tuser
);
    import pcke_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SEARCH = 3'd1;
    localparam logic [2:0] ST_FETCH  = 3'd2;
    localparam logic [2:0] ST_MUL    = 3'd3;
    localparam logic [2:0] ST_ADD    = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;

    localparam logic [1:0] LAST_STAGE = 2'd2;

    logic [2:0]                r_state, n_state;
    logic [CFG_W-1:0]          r_key_count;
    logic                      r_out_valid;
    logic [1:0]                r_stage;

    logic [DATA_W-1:0]         r_t;
    logic [CNT_W-1:0]          r_lo, r_hi, r_mid;
    logic [CNT_W-1:0]          n_lo, n_hi;
    logic [DATA_W-1:0]         r_x;
    logic signed [DATA_W-1:0]  r_acc;
    logic signed [PROD_W-1:0]  r_prod;
    logic                      r_empty;
    logic [DATA_W-1:0]         r_out_data;
    logic                      r_out_empty;

    logic                      w_accept;
    logic                      w_query;
    logic [CNT_W-1:0]          w_cnt;
    logic [CNT_W-1:0]          w_mid;
    logic [CNT_W-1:0]          w_sel;
    logic                      w_le;
    logic                      w_more;
    logic                      w_load_out;
    logic [DATA_W-1:0]         w_time;
    logic [COEF_W-1:0]         w_coef;
    logic signed [DATA_W-1:0]  w_coef_add;
    logic signed [PROD_W-1:0]  w_shift;
    logic signed [DATA_W-1:0]  w_scaled;
    logic signed [DATA_W:0]    w_sum;
    logic signed [DATA_W-1:0]  w_next_acc;
    logic signed [DATA_W:0]    w_xs;
    t_key_wr                   w_wr;
    t_key_rd                   w_rd;

    // key table
    pcke_key_store u_store (
        .i_clk  (i_clk),
        .i_wr   (w_wr),
        .i_rd   (w_rd),
        .o_time (w_time),
        .o_coef (w_coef)
    );

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_query         = (i_s_axis_tuser[0] == KIND_QUERY);
    assign w_cnt           = (r_key_count > CNT_W'(MAX_KEYS)) ? CNT_W'(MAX_KEYS)
                                                             : CNT_W'(r_key_count);
    assign w_load_out      = (r_state == ST_DONE) && (!r_out_valid || i_m_axis_tready);

    // key write port
    always_comb begin
        w_wr.en       = w_accept && (i_s_axis_tuser[0] == KIND_WRITE) &&
                        (32'(i_s_axis_tdata[OFS_KIDX +: IDX_W]) < MAX_KEYS);
        w_wr.addr     = KEY_AW'(i_s_axis_tdata[OFS_KIDX +: IDX_W]);
        w_wr.key_time = i_s_axis_tdata[OFS_KTIME +: DATA_W];
        w_wr.coef     = i_s_axis_tdata[OFS_COEF +: COEF_W];
    end

    // search step: compare the probed start time, narrow the window
    always_comb begin
        w_le   = (w_time <= r_t);
        n_lo   = w_le ? (r_mid + CNT_W'(1)) : r_lo;
        n_hi   = w_le ? r_hi : r_mid;
        w_more = (n_lo < n_hi);
        w_mid  = n_lo + ((n_hi - n_lo) >> 1);
        w_sel  = (n_lo == '0) ? '0 : (n_lo - CNT_W'(1));
    end

    // read requests: first probe on accept, next probe or final key in search
    always_comb begin
        w_rd.time_en = 1'b0;
        w_rd.coef_en = 1'b0;
        w_rd.addr    = KEY_AW'(w_cnt >> 1);
        case (r_state)
            ST_IDLE: begin
                w_rd.time_en = w_accept && w_query && (w_cnt != '0);
            end
            ST_SEARCH: begin
                w_rd.time_en = 1'b1;
                w_rd.coef_en = !w_more;
                w_rd.addr    = w_more ? w_mid[KEY_AW-1:0] : w_sel[KEY_AW-1:0];
            end
            default: begin
                w_rd.time_en = 1'b0;
            end
        endcase
    end

    // Horner stage arithmetic; shift right is floor division by 2^FRAC_BITS
    always_comb begin
        case (r_stage)
            2'd0:    w_coef_add = w_coef[COEF_SQUARE*DATA_W +: DATA_W];
            2'd1:    w_coef_add = w_coef[COEF_LINEAR*DATA_W +: DATA_W];
            default: w_coef_add = w_coef[COEF_CONST*DATA_W +: DATA_W];
        endcase
        w_xs       = {1'b0, r_x};
        w_shift    = r_prod >>> FRAC_BITS;
        w_scaled   = sat32({w_shift[PROD_W-1], w_shift});
        w_sum      = {w_scaled[DATA_W-1], w_scaled} + {w_coef_add[DATA_W-1], w_coef_add};
        w_next_acc = sat32({{(SAT_W-DATA_W-1){w_sum[DATA_W]}}, w_sum});
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && w_query) begin
                    n_state = (w_cnt == '0) ? ST_DONE : ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (!w_more) begin
                    n_state = ST_FETCH;
                end
            end
            ST_FETCH: n_state = ST_MUL;
            ST_MUL:   n_state = ST_ADD;
            ST_ADD:   n_state = (r_stage == LAST_STAGE) ? ST_DONE : ST_MUL;
            ST_DONE: begin
                if (w_load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_key_count <= '0;
            r_out_valid <= 1'b0;
            r_stage     <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_key_count <= i_cfg_wdata;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == ST_FETCH) begin
                r_stage <= '0;
            end else if (r_state == ST_ADD) begin
                r_stage <= r_stage + 2'd1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_t     <= i_s_axis_tdata[OFS_QTIME +: DATA_W];
                r_lo    <= '0;
                r_hi    <= w_cnt;
                r_mid   <= w_cnt >> 1;
                r_acc   <= '0;
                r_empty <= (w_cnt == '0);
            end
            ST_SEARCH: begin
                r_lo  <= n_lo;
                r_hi  <= n_hi;
                r_mid <= w_mid;
            end
            ST_FETCH: begin
                r_x   <= (r_t >= w_time) ? (r_t - w_time) : '0;
                r_acc <= w_coef[COEF_CUBIC*DATA_W +: DATA_W];
            end
            ST_MUL: begin
                r_prod <= r_acc * w_xs;
            end
            ST_ADD: begin
                r_acc <= w_next_acc;
            end
            default: begin
                r_prod <= r_prod;
            end
        endcase
        if (w_load_out) begin
            r_out_data  <= r_acc;
            r_out_empty <= r_empty;
        end
    end

    assign o_m_axis_tvalid   = r_out_valid;
    assign o_m_axis_tdata    = r_out_data;
    assign o_m_axis_tuser[0] = r_out_empty;

`include "piecewise_cubic_key_evaluator_core_assert.svh"

    // search window is never empty while probing
    `PCKE_ASSERT_SAME(a_search_window, i_clk, i_rst_n, r_state == ST_SEARCH, r_lo < r_hi)
    // Horner stage index stays within the three stages
    `PCKE_ASSERT_SAME(a_stage_range, i_clk, i_rst_n, (r_state == ST_MUL) || (r_state == ST_ADD), r_stage <= LAST_STAGE)
    // a new output beat only comes from the done state
    `PCKE_ASSERT_SAME(a_out_from_done, i_clk, i_rst_n, $rose(o_m_axis_tvalid), $past(r_state) == ST_DONE)
    // an accepted query always leaves idle
    `PCKE_ASSERT_NEXT(a_query_busy, i_clk, i_rst_n, w_accept && w_query, r_state != ST_IDLE)

endmodule
`default_nettype wire

[test/tb_piecewise_cubic_key_evaluator_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_piecewise_cubic_key_evaluator_core
// Self-checking bench for the piecewise cubic key evaluator. A walked table of
// directed beats covers the empty table, saturation at both rails, offset
// clamping and floor truncation. Randomized phases follow, each setting a key
// count, loading a sorted key table (unless the count is oversized), firing
// queries near key boundaries, with some rewrites that may unsort the table.
// Results are checked against directed values or a fixed-point curve predictor.
// ----------------------------------------------------------------------------
module tb_piecewise_cubic_key_evaluator_core;
    import pcke_pkg::*;

    localparam int CLK_HALF          = 5;
    localparam int RESET_CYCLES      = 6;
    localparam int SETTLE_CYCLES     = 24;
    localparam int QUIET_LIMIT       = 4000;
    localparam int QUERIES_PER_PHASE = 60;
    localparam int REPORT_LIMIT      = 10;
    localparam int NUM_PHASES        = 15;

    localparam logic [DATA_W-1:0] VAL_MAX = 32'h7fff_ffff;
    localparam logic [DATA_W-1:0] VAL_MIN = 32'h8000_0000;
    localparam logic [DATA_W-1:0] Q_ONE   = 32'h0001_0000;
    localparam logic [DATA_W-1:0] ALL_ONE = 32'hffff_ffff;
    localparam longint SAT_HI = 64'sd2147483647;
    localparam longint SAT_LO = -64'sd2147483648;

    typedef enum logic [1:0] {ROW_CFG, ROW_WRITE, ROW_QUERY} row_op_e;

    // one input beat, last field (key_index) in the lowest bits
    typedef struct packed {
        logic [DATA_W-1:0] query_time;
        logic [DATA_W-1:0] coef_const;
        logic [DATA_W-1:0] coef_linear;
        logic [DATA_W-1:0] coef_square;
        logic [DATA_W-1:0] coef_cubic;
        logic [DATA_W-1:0] key_time;
        logic [IDX_W-1:0]  key_index;
    } curve_beat_t;

    typedef struct {
        logic [DATA_W-1:0] value;
        logic              empty;
    } curve_result_t;

    typedef struct {
        row_op_e           op;
        logic [CFG_W-1:0]  count;
        curve_beat_t       beat;
        bit                typed;
        logic [DATA_W-1:0] want_value;
        logic              want_empty;
    } directed_row_t;

    // clock, reset and bench-driven inputs
    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cfg_we    = 1'b0;
    logic [CFG_W-1:0]   cfg_wdata = '0;
    logic               s_tvalid  = 1'b0;
    logic [IN_W-1:0]    s_tdata   = '0;
    logic [0:0]         s_tuser   = KIND_WRITE;
    logic               m_tready  = 1'b0;
    logic               s_tready;
    logic               m_tvalid;
    logic [DATA_W-1:0]  m_tdata;
    logic [0:0]         m_tuser;

    // shadow of the block's table and count
    logic [DATA_W-1:0]        key_time_shadow [MAX_KEYS];
    logic signed [DATA_W-1:0] key_coef_shadow [MAX_KEYS][4];
    logic [CFG_W-1:0]         key_count_shadow = '0;

    curve_result_t pending_results [$];
    directed_row_t directed_rows [$];
    int            mismatch_count = 0;
    int            quiet_cycles   = 0;
    int unsigned   send_idle_pct  = 0;
    int unsigned   recv_idle_pct  = 0;

    always #CLK_HALF clk = ~clk;

    piecewise_cubic_key_evaluator_core i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),   // key_index, key_time, 4 coefs, query_time
        .i_s_axis_tuser  (s_tuser),   // kind
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),   // curve_value
        .o_m_axis_tuser  (m_tuser)    // empty_table
    );

    // clamp to the signed 32-bit range
    function automatic logic signed [DATA_W-1:0] clamp32(input longint v);
        if (v > SAT_HI) begin
            return VAL_MAX;
        end else if (v < SAT_LO) begin
            return VAL_MIN;
        end
        return v[DATA_W-1:0];
    endfunction

    // one Horner stage: floor(acc * x / 2^16), saturate, add coef, saturate
    function automatic logic signed [DATA_W-1:0] horner_step(
        input logic signed [DATA_W-1:0] acc,
        input logic [DATA_W-1:0]        x,
        input logic signed [DATA_W-1:0] coef
    );
        longint prod;
        longint scaled;
        prod   = longint'(acc) * longint'({32'd0, x});
        scaled = prod >>> FRAC_BITS;
        return clamp32(longint'(clamp32(scaled)) + longint'(coef));
    endfunction

    // curve value at a query time against the shadow table
    function automatic void predict_query(
        input  logic [DATA_W-1:0] qtime,
        output logic [DATA_W-1:0] value,
        output logic              empty
    );
        int unsigned              n;
        int unsigned              lo;
        int unsigned              hi;
        int unsigned              mid;
        int unsigned              sel;
        logic [DATA_W-1:0]        x;
        logic signed [DATA_W-1:0] acc;
        n = (key_count_shadow > MAX_KEYS) ? MAX_KEYS : key_count_shadow;
        if (n == 0) begin
            value = '0;
            empty = 1'b1;
        end else begin
            lo = 0;
            hi = n;
            while (lo < hi) begin
                mid = lo + (hi - lo) / 2;
                if (key_time_shadow[mid] <= qtime) begin
                    lo = mid + 1;
                end else begin
                    hi = mid;
                end
            end
            sel = (lo == 0) ? 0 : lo - 1;
            // offset clamps at zero when the query precedes the key
            x   = (qtime >= key_time_shadow[sel]) ? qtime - key_time_shadow[sel] : '0;
            acc = horner_step(key_coef_shadow[sel][COEF_CUBIC], x,
                              key_coef_shadow[sel][COEF_SQUARE]);
            acc = horner_step(acc, x, key_coef_shadow[sel][COEF_LINEAR]);
            acc = horner_step(acc, x, key_coef_shadow[sel][COEF_CONST]);
            value = acc;
            empty = 1'b0;
        end
    endfunction

    function automatic curve_beat_t rand_beat();
        curve_beat_t b;
        b.key_index   = IDX_W'($urandom_range(0, MAX_KEYS - 1));
        b.key_time    = $urandom;
        b.coef_cubic  = $urandom;
        b.coef_square = $urandom;
        b.coef_linear = $urandom;
        b.coef_const  = $urandom;
        b.query_time  = $urandom;
        return b;
    endfunction

    // mostly small coefficients so that short offsets stay off the rails
    function automatic logic [DATA_W-1:0] rand_coef();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
            2: return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
            3: begin
                case ($urandom_range(0, 4))
                    0: return VAL_MAX;
                    1: return VAL_MIN;
                    2: return Q_ONE;
                    3: return ALL_ONE;
                    default: return '0;
                endcase
            end
            default: return $urandom_range(0, 32'h0000_4000) - 32'h0000_2000;
        endcase
    endfunction

    task automatic note_mismatch(
        input string             what,
        input logic [DATA_W-1:0] want,
        input logic [DATA_W-1:0] got
    );
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("%0t: %s mismatch: expected %h got %h", $realtime, what, want, got);
        end
    endtask

    // drive one beat, hold it until taken, then update the shadow state
    task automatic send_beat(
        input logic              kind,
        input curve_beat_t       beat,
        input bit                typed,
        input logic [DATA_W-1:0] want_value,
        input logic              want_empty
    );
        curve_result_t r;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= beat;
        s_tuser  <= kind;
        do @(posedge clk); while (!s_tready);
        if (kind == KIND_WRITE) begin
            key_time_shadow[beat.key_index]              = beat.key_time;
            key_coef_shadow[beat.key_index][COEF_CUBIC]  = beat.coef_cubic;
            key_coef_shadow[beat.key_index][COEF_SQUARE] = beat.coef_square;
            key_coef_shadow[beat.key_index][COEF_LINEAR] = beat.coef_linear;
            key_coef_shadow[beat.key_index][COEF_CONST]  = beat.coef_const;
        end else begin
            if (typed) begin
                r.value = want_value;
                r.empty = want_empty;
            end else begin
                predict_query(beat.query_time, r.value, r.empty);
            end
            pending_results.insert(pending_results.size(), r);
        end
    endtask

    // wait for every pending result, then let the search pipeline go quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_key_count(input logic [CFG_W-1:0] cnt);
        cfg_we    <= 1'b1;
        cfg_wdata <= cnt;
        @(posedge clk);
        cfg_we    <= 1'b0;
        key_count_shadow = cnt;
    endtask

    // directed table rows
    task automatic row_cfg(input logic [CFG_W-1:0] cnt);
        directed_row_t row;
        row.op    = ROW_CFG;
        row.count = cnt;
        row.beat  = rand_beat();
        row.typed = 1'b0;
        directed_rows.insert(directed_rows.size(), row);
    endtask

    task automatic row_key(
        input logic [IDX_W-1:0]  idx,
        input logic [DATA_W-1:0] ktime,
        input logic [DATA_W-1:0] a,
        input logic [DATA_W-1:0] b,
        input logic [DATA_W-1:0] c,
        input logic [DATA_W-1:0] d
    );
        directed_row_t row;
        row.op               = ROW_WRITE;
        row.count            = '0;
        row.beat             = rand_beat();
        row.beat.key_index   = idx;
        row.beat.key_time    = ktime;
        row.beat.coef_cubic  = a;
        row.beat.coef_square = b;
        row.beat.coef_linear = c;
        row.beat.coef_const  = d;
        row.typed            = 1'b0;
        directed_rows.insert(directed_rows.size(), row);
    endtask

    task automatic row_query(
        input logic [DATA_W-1:0] qtime,
        input bit                typed,
        input logic [DATA_W-1:0] want_value,
        input logic              want_empty
    );
        directed_row_t row;
        row.op              = ROW_QUERY;
        row.count           = '0;
        row.beat            = rand_beat();
        row.beat.query_time = qtime;
        row.typed           = typed;
        row.want_value      = want_value;
        row.want_empty      = want_empty;
        directed_rows.insert(directed_rows.size(), row);
    endtask

    // one random phase: set the count, load a sorted table unless oversized, then query
    task automatic run_phase(input int cnt);
        int unsigned       n;
        int unsigned       s;
        longint unsigned   step_cap;
        longint unsigned   t;
        logic [DATA_W-1:0] tk;
        curve_beat_t       beat;
        settle();
        set_key_count(CFG_W'(cnt));
        n = (cnt > MAX_KEYS) ? MAX_KEYS : cnt;

        // an oversized count reuses the full table of the previous phase
        if (cnt <= MAX_KEYS) begin
            step_cap = ($urandom_range(0, 1) == 0) ? 64'hffff_ffff / (n + 1) : 64'h0002_0000;
            t = $urandom_range(0, int'(step_cap));
            for (int i = 0; i < n; i++) begin
                beat             = rand_beat();
                beat.key_index   = IDX_W'(i);
                beat.key_time    = t[DATA_W-1:0];
                beat.coef_cubic  = rand_coef();
                beat.coef_square = rand_coef();
                beat.coef_linear = rand_coef();
                beat.coef_const  = rand_coef();
                send_beat(KIND_WRITE, beat, 1'b0, '0, 1'b0);
                t += $urandom_range(0, int'(step_cap));
            end
        end

        for (int q = 0; q < QUERIES_PER_PHASE; q++) begin
            // occasional rewrite; a fresh start time may unsort the table
            if ($urandom_range(0, 99) < 15) begin
                beat = rand_beat();
                if (n > 0 && $urandom_range(0, 4) != 0) begin
                    beat.key_index = IDX_W'($urandom_range(0, n - 1));
                    if ($urandom_range(0, 9) < 7) begin
                        beat.key_time = key_time_shadow[beat.key_index];
                    end
                end
                beat.coef_cubic  = rand_coef();
                beat.coef_square = rand_coef();
                beat.coef_linear = rand_coef();
                beat.coef_const  = rand_coef();
                send_beat(KIND_WRITE, beat, 1'b0, '0, 1'b0);
            end

            // queries cluster around key start times
            beat = rand_beat();
            if (n > 0) begin
                s  = $urandom_range(0, n - 1);
                tk = key_time_shadow[s];
                case ($urandom_range(0, 5))
                    0, 1: beat.query_time = tk + $urandom_range(0, 32'h0003_ffff);
                    2:    beat.query_time = tk + $urandom_range(0, 32'h0000_00ff);
                    3:    beat.query_time = tk;
                    4:    beat.query_time = tk - 1;
                    default: ;
                endcase
            end
            send_beat(KIND_QUERY, beat, 1'b0, '0, 1'b0);
        end
    endtask

    // receiver back-pressure
    always @(posedge clk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // result checker
    always @(posedge clk) begin
        curve_result_t want;
        if (rst_n && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                note_mismatch("unexpected result beat", '0, m_tdata);
            end else begin
                want = pending_results.pop_front();
                if (m_tdata !== want.value) begin
                    note_mismatch("curve_value", want.value, m_tdata);
                end
                if (m_tuser[0] !== want.empty) begin
                    note_mismatch("empty_table", {31'd0, want.empty}, {31'd0, m_tuser[0]});
                end
            end
        end
    end

    // watchdog on beats in either direction
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", quiet_cycles);
            $display("tb_piecewise_cubic_key_evaluator_core NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int phase_counts [NUM_PHASES] = '{1, 256, 511, 0, 5, 16, 2, 64, 9, 256,
                                          3, 33, 7, 12, 1};

        // empty table straight out of reset
        row_query(32'h0000_0000, 1'b1, '0, 1'b1);
        row_query(ALL_ONE, 1'b1, '0, 1'b1);
        // single key, constant and rail-hitting cubics
        row_key(8'd0, 32'h0, '0, '0, '0, VAL_MAX);
        row_cfg(9'd1);
        row_query(32'h1234_5678, 1'b1, VAL_MAX, 1'b0);
        row_key(8'd0, 32'h0, VAL_MAX, '0, '0, '0);
        row_query(ALL_ONE, 1'b1, VAL_MAX, 1'b0);
        row_key(8'd0, 32'h0, VAL_MIN, '0, '0, '0);
        row_query(ALL_ONE, 1'b1, VAL_MIN, 1'b0);
        // query ahead of every key: offset clamps to zero, only the const is left
        row_key(8'd0, Q_ONE, VAL_MAX, ALL_ONE, 32'h1234_5678, VAL_MIN);
        row_query(32'h0000_0000, 1'b1, VAL_MIN, 1'b0);
        row_query(Q_ONE, 1'b1, VAL_MIN, 1'b0);
        // three keys: constant-ish, linear, square; top slot written too
        row_key(8'd1, 32'h0002_0000, '0, '0, Q_ONE, '0);
        row_key(8'd2, 32'h0003_0000, '0, Q_ONE, '0, '0);
        row_key(8'd255, ALL_ONE, 32'h5a5a_5a5a, 32'ha5a5_a5a5, 32'h3c3c_3c3c, 32'hc3c3_c3c3);
        row_cfg(9'd3);
        row_query(32'h0002_8000, 1'b1, 32'h0000_8000, 1'b0);
        row_query(32'h0003_8000, 1'b0, '0, 1'b0);
        row_query(32'h0001_ffff, 1'b0, '0, 1'b0);
        row_query(ALL_ONE, 1'b0, '0, 1'b0);
        // negative product truncates toward minus infinity
        row_key(8'd1, 32'h0002_0000, '0, '0, ALL_ONE, '0);
        row_query(32'h0002_0001, 1'b0, '0, 1'b0);
        row_cfg(9'd0);
        row_query(32'h0002_0001, 1'b1, '0, 1'b1);

        send_idle_pct = 36;
        recv_idle_pct = 75;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            case (directed_rows[i].op)
                ROW_CFG: begin
                    settle();
                    set_key_count(directed_rows[i].count);
                end
                ROW_WRITE: begin
                    send_beat(KIND_WRITE, directed_rows[i].beat, 1'b0, '0, 1'b0);
                end
                default: begin
                    send_beat(KIND_QUERY, directed_rows[i].beat, directed_rows[i].typed,
                              directed_rows[i].want_value, directed_rows[i].want_empty);
                end
            endcase
        end

        // idle mix: slow receiver, then slow sender, then full rate
        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p == 5) begin
                send_idle_pct = 75;
                recv_idle_pct = 36;
            end else if (p == 10) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            run_phase(phase_counts[p]);
        end

        settle();
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("tb_piecewise_cubic_key_evaluator_core OK");
        end else begin
            $display("tb_piecewise_cubic_key_evaluator_core NOT OK");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+design
design/pcke_pkg.sv
design/pcke_key_store.sv
design/piecewise_cubic_key_evaluator_core.sv
test/tb_piecewise_cubic_key_evaluator_core.sv
